### design/bristorbrot_escape_test_unit_defines.svh
// Assertion macros shared by the Bristorbrot escape test unit.
// No dependencies; included by the top level.
`ifndef BRISTORBROT_ESCAPE_TEST_UNIT_DEFINES_SVH
`define BRISTORBROT_ESCAPE_TEST_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising edge out of reset.
`define BBET_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion %m failed");
// Next-cycle implication, checked at every rising edge out of reset.
`define BBET_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion %m failed");
`else
`define BBET_ASSERT_IMP(label, clk, rstn, ante, cons)
`define BBET_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

### design/bbet_pkg.sv
// Shared types and constants of the Bristorbrot escape test unit.
// No dependencies; used by the controller, the datapath and the multiplier.
package bbet_pkg;

    localparam int DEF_COORD_BITS = 16;
    localparam int DEF_WORK_BITS  = 32;

    // Integer bits of a working value; the rest are fraction bits.
    localparam int WORK_INT_BITS = 8;

    localparam int LIMIT_W     = 8;
    localparam int BOUND_W     = 12;
    localparam int ISCALE_W    = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_ITER_LIMIT   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ESCAPE_BOUND = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INV_SCALE    = 2'd2;

    localparam logic [LIMIT_W-1:0]  RST_ITER_LIMIT   = 8'd30;
    localparam logic [BOUND_W-1:0]  RST_ESCAPE_BOUND = 12'd200;
    localparam logic [ISCALE_W-1:0] RST_INV_SCALE    = 16'd12412;

    // Sequencer step counts (last index of each multi-cycle step).
    localparam logic [1:0] SCALE_LAST  = 2'd3;
    localparam logic [1:0] SQUARE_LAST = 2'd2;

    typedef enum logic [1:0] {
        AX_X,
        AX_Y,
        AX_Z
    } axis_t;

    // Multiplier operations; the code also names the destination register.
    typedef enum logic [2:0] {
        MOP_XX,
        MOP_YY,
        MOP_ZZ,
        MOP_NY,
        MOP_NZ
    } mul_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_SQUARE,
        ST_SQ_WAIT,
        ST_ADDS,
        ST_MUL_NY,
        ST_MUL_NZ,
        ST_MUL_XX,
        ST_WAIT_XYZ,
        ST_UPD_YZ,
        ST_MUL_YY,
        ST_MUL_ZZ,
        ST_WAIT_SQ,
        ST_CHECK,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic    load;
        logic    scale_mul;
        axis_t   scale_sel;
        logic    scale_wr;
        axis_t   scale_wsel;
        logic    mul_issue;
        mul_op_t mul_op;
        logic    adds;
        logic    upd_x;
        logic    upd_yz;
        logic    emit;
    } bbet_cmd_t;

    typedef struct packed {
        logic pipe_empty;
        logic escape;
        logic out_free;
    } bbet_status_t;

endpackage

### design/bristorbrot_escape_test_unit.sv
// Top level of the Bristorbrot escape test unit: configuration registers,
// sequencer and datapath. Depends on bbet_pkg, bbet_ctrl, bbet_datapath and the defines header.
//
// The unit takes one voxel position per item (three signed Q3.12 coordinates),
// scales it by the inverse_scale register into the constant c and iterates the
// Bristorbrot map z' = (x*x - y*y - z*z, y*(2x - z), z*(2x + y)) + c from z = c,
// in saturating Q8.24 arithmetic. If the orbit stays within escape_bound for
// iteration_limit iterations, the voxel's coordinates come out as one result
// item; a voxel that escapes, or whose arithmetic saturates, produces nothing.
// Items are handled one at a time. All products go through one shared
// multiplier with three pipeline stages. Each map iteration issues five
// products in two dependent groups, and the pipeline drains after each group.
// With a limit of zero the voxel comes out after scaling alone, even if the
// scaling saturated. A finished result sits in an output register, so the
// next item is accepted while it waits for m_ready.
// Configuration writes are always taken (cfg_ready is tied high) and must only
// be made while the unit is idle; writes to an index beyond the register list
// are ignored.
`include "bristorbrot_escape_test_unit_defines.svh"

module bristorbrot_escape_test_unit #(
    parameter int COORD_BITS = bbet_pkg::DEF_COORD_BITS,
    parameter int WORK_BITS  = bbet_pkg::DEF_WORK_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [COORD_BITS-1:0]        s_coord_x,
    input  logic signed [COORD_BITS-1:0]        s_coord_y,
    input  logic signed [COORD_BITS-1:0]        s_coord_z,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [COORD_BITS-1:0]        m_voxel_x,
    output logic signed [COORD_BITS-1:0]        m_voxel_y,
    output logic signed [COORD_BITS-1:0]        m_voxel_z,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bbet_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bbet_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import bbet_pkg::*;

    logic [LIMIT_W-1:0]  iteration_limit_reg;
    logic [BOUND_W-1:0]  escape_bound_reg;
    logic [ISCALE_W-1:0] inverse_scale_reg;

    bbet_cmd_t    cmd;
    bbet_status_t status;

    // The register file accepts a write in every cycle. Each register keeps
    // only the low bits that its width allows.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iteration_limit_reg <= RST_ITER_LIMIT;
            escape_bound_reg    <= RST_ESCAPE_BOUND;
            inverse_scale_reg   <= RST_INV_SCALE;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_ITER_LIMIT:   iteration_limit_reg <= cfg_data[LIMIT_W-1:0];
                CFG_ESCAPE_BOUND: escape_bound_reg    <= cfg_data[BOUND_W-1:0];
                CFG_INV_SCALE:    inverse_scale_reg   <= cfg_data[ISCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The sequencer decides what happens in each cycle; the datapath only
    // reports whether the multiplier is drained, whether the orbit escaped
    // and whether the output register can take a new item.
    bbet_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .iteration_limit (iteration_limit_reg),
        .cmd             (cmd),
        .status          (status)
    );

    bbet_datapath #(
        .COORD_BITS (COORD_BITS),
        .WORK_BITS  (WORK_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_coord_x     (s_coord_x),
        .s_coord_y     (s_coord_y),
        .s_coord_z     (s_coord_z),
        .escape_bound  (escape_bound_reg),
        .inverse_scale (inverse_scale_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_voxel_x     (m_voxel_x),
        .m_voxel_y     (m_voxel_y),
        .m_voxel_z     (m_voxel_z)
    );

    // A result is only written into the output register when it is free.
    `BBET_ASSERT_IMP(a_emit_needs_room, aclk, aresetn, cmd.emit, status.out_free)
    // Once an item is taken the unit is busy in the following cycle.
    `BBET_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    // The multiplier is never started while the unit waits for an item.
    `BBET_ASSERT_IMP(a_no_issue_when_idle, aclk, aresetn, cmd.mul_issue, !s_ready)

endmodule

### design/bbet_mul.sv
// Pipelined saturating fixed-point multiplier of the escape test datapath.
// Depends on bbet_pkg; result is (a * b) >> fraction bits, saturated.
module bbet_mul #(
    parameter int WORK_BITS = bbet_pkg::DEF_WORK_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        issue,
    input  bbet_pkg::mul_op_t           op,
    input  logic signed [WORK_BITS-1:0] a,
    input  logic signed [WORK_BITS-1:0] b,
    output logic                        res_valid,
    output bbet_pkg::mul_op_t           res_op,
    output logic signed [WORK_BITS-1:0] res_value,
    output logic                        res_sat,
    output logic                        empty
);
    import bbet_pkg::*;

    localparam int W   = WORK_BITS;
    localparam int F   = W - WORK_INT_BITS;
    localparam int NCH = (W + 31) / 32;
    localparam int CW  = (W + NCH - 1) / NCH;
    localparam int PW  = NCH * CW;
    localparam int PRW = 2 * PW;
    localparam int MW  = PRW - F;

    logic           v1_reg, v2_reg, v3_reg;
    mul_op_t        op1_reg, op2_reg, op3_reg;
    logic           neg1_reg, neg2_reg, neg3_reg;
    logic [PW-1:0]  ma1_reg, mb1_reg;
    logic [2*CW-1:0] pp_reg [NCH*NCH];
    logic [PRW-1:0] prod_reg;

    logic [W-1:0]   a_mag, b_mag;
    logic [PRW-1:0] prod_next;
    logic [MW-1:0]  mag;
    logic           hi_any, pos_over, neg_over;

    assign a_mag = a[W-1] ? W'(-a) : W'(a);
    assign b_mag = b[W-1] ? W'(-b) : W'(b);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        op1_reg  <= op;
        neg1_reg <= a[W-1] ^ b[W-1];
        ma1_reg  <= PW'(a_mag);
        mb1_reg  <= PW'(b_mag);
        op2_reg  <= op1_reg;
        neg2_reg <= neg1_reg;
        op3_reg  <= op2_reg;
        neg3_reg <= neg2_reg;
        prod_reg <= prod_next;
    end

    // Partial products of chunks no wider than 32 bits, one multiplier each.
    for (genvar i = 0; i < NCH; i++) begin : g_row
        for (genvar j = 0; j < NCH; j++) begin : g_col
            always_ff @(posedge aclk) begin
                pp_reg[i*NCH+j] <= ma1_reg[i*CW +: CW] * mb1_reg[j*CW +: CW];
            end
        end
    end

    always_comb begin
        prod_next = '0;
        for (int i = 0; i < NCH; i++) begin
            for (int j = 0; j < NCH; j++) begin
                prod_next = prod_next + (PRW'(pp_reg[i*NCH+j]) << (CW * (i + j)));
            end
        end
    end

    // Drop the fraction bits and clamp the magnitude to the working range.
    assign mag      = prod_reg[PRW-1:F];
    assign hi_any   = |mag[MW-1:W];
    assign pos_over = hi_any | mag[W-1];
    assign neg_over = hi_any | (mag[W-1] & (|mag[W-2:0]));

    always_comb begin
        if (neg3_reg) begin
            res_sat   = neg_over;
            res_value = neg_over ? {1'b1, {(W-1){1'b0}}} : -mag[W-1:0];
        end else begin
            res_sat   = pos_over;
            res_value = pos_over ? {1'b0, {(W-1){1'b1}}} : mag[W-1:0];
        end
    end

    assign res_valid = v3_reg;
    assign res_op    = op3_reg;
    assign empty     = !(v1_reg || v2_reg || v3_reg);

endmodule

### design/bbet_datapath.sv
// Datapath of the escape test: coordinate scaling, orbit registers,
// saturating adders, shared multiplier and output stage. Depends on bbet_pkg, bbet_mul.
module bbet_datapath #(
    parameter int COORD_BITS = bbet_pkg::DEF_COORD_BITS,
    parameter int WORK_BITS  = bbet_pkg::DEF_WORK_BITS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  bbet_pkg::bbet_cmd_t              cmd,
    output bbet_pkg::bbet_status_t           status,
    input  logic signed [COORD_BITS-1:0]     s_coord_x,
    input  logic signed [COORD_BITS-1:0]     s_coord_y,
    input  logic signed [COORD_BITS-1:0]     s_coord_z,
    input  logic [bbet_pkg::BOUND_W-1:0]     escape_bound,
    input  logic [bbet_pkg::ISCALE_W-1:0]    inverse_scale,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [COORD_BITS-1:0]     m_voxel_x,
    output logic signed [COORD_BITS-1:0]     m_voxel_y,
    output logic signed [COORD_BITS-1:0]     m_voxel_z
);
    import bbet_pkg::*;

    localparam int C        = COORD_BITS;
    localparam int W        = WORK_BITS;
    localparam int F        = W - WORK_INT_BITS;
    localparam int SPW      = C + ISCALE_W + 1;
    localparam int SMW      = C + ISCALE_W;
    localparam int SH       = W - C - ISCALE_W;
    localparam int SCALE_SW = (SH >= 0) ? W : SMW;
    localparam int BW       = BOUND_W + F;

    localparam logic signed [W+1:0] SAT_MAX = {3'b000, {(W-1){1'b1}}};
    localparam logic signed [W+1:0] SAT_MIN = {3'b111, {(W-1){1'b0}}};

    // Saturating add; bit W of the result flags saturation.
    function automatic logic [W:0] sat_add(input logic signed [W:0] a,
                                           input logic signed [W:0] b);
        logic signed [W+1:0] s;
        s = (W+2)'(a) + (W+2)'(b);
        if (s > SAT_MAX) begin
            return {1'b1, SAT_MAX[W-1:0]};
        end else if (s < SAT_MIN) begin
            return {1'b1, SAT_MIN[W-1:0]};
        end
        return {1'b0, s[W-1:0]};
    endfunction

    logic signed [C-1:0] coord_x_reg, coord_y_reg, coord_z_reg;
    logic signed [SPW-1:0] scale_prod_reg;
    logic signed [W-1:0] cx_reg, cy_reg, cz_reg;
    logic signed [W-1:0] x_reg, y_reg, z_reg;
    logic signed [W-1:0] xx_reg, yy_reg, zz_reg;
    logic signed [W-1:0] ny_reg, nz_reg;
    logic signed [W-1:0] t1_reg, t2_reg, nx_reg;
    logic                sat_reg, sat_next;
    logic                m_valid_reg;
    logic signed [C-1:0] m_voxel_x_reg, m_voxel_y_reg, m_voxel_z_reg;

    // Coordinate scaling.
    logic signed [C-1:0]   coord_sel;
    logic signed [SPW-1:0] sc_a, sc_b;
    logic [SPW-1:0]        sc_abs;
    logic [SMW-1:0]        sc_mag;
    logic [SCALE_SW-1:0]   sc_shifted;
    logic [SCALE_SW:0]     sc_ext;
    logic                  sc_neg, sc_hi, sc_pos_over, sc_neg_over, sc_sat;
    logic signed [W-1:0]   sc_val;

    always_comb begin
        unique case (cmd.scale_sel)
            AX_X:    coord_sel = coord_x_reg;
            AX_Y:    coord_sel = coord_y_reg;
            AX_Z:    coord_sel = coord_z_reg;
            default: coord_sel = coord_x_reg;
        endcase
    end

    assign sc_a   = SPW'(coord_sel);
    assign sc_b   = SPW'(inverse_scale);
    assign sc_neg = scale_prod_reg[SPW-1];
    assign sc_abs = sc_neg ? SPW'(-scale_prod_reg) : SPW'(scale_prod_reg);
    assign sc_mag = sc_abs[SMW-1:0];

    if (SH >= 0) begin : g_scale_up
        assign sc_shifted = SCALE_SW'(sc_mag) << SH;
    end else begin : g_scale_down
        assign sc_shifted = sc_mag >> (-SH);
    end

    assign sc_ext      = (SCALE_SW+1)'(sc_shifted);
    assign sc_hi       = |sc_ext[SCALE_SW:W];
    assign sc_pos_over = sc_hi | sc_ext[W-1];
    assign sc_neg_over = sc_hi | (sc_ext[W-1] & (|sc_ext[W-2:0]));

    always_comb begin
        if (sc_neg) begin
            sc_sat = sc_neg_over;
            sc_val = sc_neg_over ? SAT_MIN[W-1:0] : -sc_ext[W-1:0];
        end else begin
            sc_sat = sc_pos_over;
            sc_val = sc_pos_over ? SAT_MAX[W-1:0] : sc_ext[W-1:0];
        end
    end

    // Orbit arithmetic, all from registers.
    logic [W:0]          x2_r, t1_r, t2_r, d1_r, nx_r, xn_r, yn_r, zn_r, e1_r, e2_r;
    logic signed [W-1:0] x2_v, d1_v, e1_v;
    logic [BW-1:0]       d_ext, bound_ext;
    logic                escape;

    assign x2_r = sat_add((W+1)'(x_reg), (W+1)'(x_reg));
    assign x2_v = x2_r[W-1:0];
    assign t1_r = sat_add((W+1)'(x2_v), -((W+1)'(z_reg)));
    assign t2_r = sat_add((W+1)'(x2_v), (W+1)'(y_reg));
    assign d1_r = sat_add((W+1)'(xx_reg), -((W+1)'(yy_reg)));
    assign d1_v = d1_r[W-1:0];
    assign nx_r = sat_add((W+1)'(d1_v), -((W+1)'(zz_reg)));
    assign xn_r = sat_add((W+1)'(nx_reg), (W+1)'(cx_reg));
    assign yn_r = sat_add((W+1)'(ny_reg), (W+1)'(cy_reg));
    assign zn_r = sat_add((W+1)'(nz_reg), (W+1)'(cz_reg));
    assign e1_r = sat_add((W+1)'(xx_reg), (W+1)'(yy_reg));
    assign e1_v = e1_r[W-1:0];
    assign e2_r = sat_add((W+1)'(e1_v), (W+1)'(zz_reg));

    // The orbit has escaped when the squared magnitude exceeds bound * 2^F or any arithmetic saturated.
    assign d_ext     = BW'(e2_r[W-1:0]);
    assign bound_ext = {escape_bound, {F{1'b0}}};
    assign escape    = sat_reg | e1_r[W] | e2_r[W] | e2_r[W-1] | (d_ext > bound_ext);

    // Shared multiplier.
    logic signed [W-1:0] mul_a, mul_b, mul_value;
    logic                mul_valid, mul_sat, mul_empty;
    mul_op_t             mul_res_op;

    always_comb begin
        unique case (cmd.mul_op)
            MOP_XX: begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
            MOP_YY: begin
                mul_a = y_reg;
                mul_b = y_reg;
            end
            MOP_ZZ: begin
                mul_a = z_reg;
                mul_b = z_reg;
            end
            MOP_NY: begin
                mul_a = y_reg;
                mul_b = t1_reg;
            end
            MOP_NZ: begin
                mul_a = z_reg;
                mul_b = t2_reg;
            end
            default: begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
        endcase
    end

    bbet_mul #(
        .WORK_BITS (W)
    ) u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .issue     (cmd.mul_issue),
        .op        (cmd.mul_op),
        .a         (mul_a),
        .b         (mul_b),
        .res_valid (mul_valid),
        .res_op    (mul_res_op),
        .res_value (mul_value),
        .res_sat   (mul_sat),
        .empty     (mul_empty)
    );

    // Any saturation during the item is remembered until the next item is loaded.
    always_comb begin
        sat_next = sat_reg;
        if (cmd.load) begin
            sat_next = 1'b0;
        end
        if (cmd.scale_wr && sc_sat) begin
            sat_next = 1'b1;
        end
        if (cmd.adds && (x2_r[W] || t1_r[W] || t2_r[W] || d1_r[W] || nx_r[W])) begin
            sat_next = 1'b1;
        end
        if (cmd.upd_x && xn_r[W]) begin
            sat_next = 1'b1;
        end
        if (cmd.upd_yz && (yn_r[W] || zn_r[W])) begin
            sat_next = 1'b1;
        end
        if (mul_valid && mul_sat) begin
            sat_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sat_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            sat_reg <= sat_next;
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            coord_x_reg <= s_coord_x;
            coord_y_reg <= s_coord_y;
            coord_z_reg <= s_coord_z;
        end
        if (cmd.scale_mul) begin
            scale_prod_reg <= sc_a * sc_b;
        end
        if (cmd.scale_wr) begin
            unique case (cmd.scale_wsel)
                AX_X: begin
                    cx_reg <= sc_val;
                    x_reg  <= sc_val;
                end
                AX_Y: begin
                    cy_reg <= sc_val;
                    y_reg  <= sc_val;
                end
                AX_Z: begin
                    cz_reg <= sc_val;
                    z_reg  <= sc_val;
                end
                default: begin
                end
            endcase
        end
        if (cmd.adds) begin
            t1_reg <= t1_r[W-1:0];
            t2_reg <= t2_r[W-1:0];
            nx_reg <= nx_r[W-1:0];
        end
        if (cmd.upd_x) begin
            x_reg <= xn_r[W-1:0];
        end
        if (cmd.upd_yz) begin
            y_reg <= yn_r[W-1:0];
            z_reg <= zn_r[W-1:0];
        end
        if (mul_valid) begin
            unique case (mul_res_op)
                MOP_XX:  xx_reg <= mul_value;
                MOP_YY:  yy_reg <= mul_value;
                MOP_ZZ:  zz_reg <= mul_value;
                MOP_NY:  ny_reg <= mul_value;
                MOP_NZ:  nz_reg <= mul_value;
                default: begin
                end
            endcase
        end
        if (cmd.emit) begin
            m_voxel_x_reg <= coord_x_reg;
            m_voxel_y_reg <= coord_y_reg;
            m_voxel_z_reg <= coord_z_reg;
        end
    end

    always_comb begin
        status.pipe_empty = mul_empty;
        status.escape     = escape;
        status.out_free   = !m_valid_reg || m_ready;
    end

    assign m_valid   = m_valid_reg;
    assign m_voxel_x = m_voxel_x_reg;
    assign m_voxel_y = m_voxel_y_reg;
    assign m_voxel_z = m_voxel_z_reg;

endmodule

### design/bbet_ctrl.sv
// Sequencer of the escape test: steps one voxel through scaling and the map.
// Depends on bbet_pkg; drives the datapath through bbet_cmd_t.
module bbet_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bbet_pkg::LIMIT_W-1:0]  iteration_limit,
    output bbet_pkg::bbet_cmd_t           cmd,
    input  bbet_pkg::bbet_status_t        status
);
    import bbet_pkg::*;

    ctrl_state_t        state_reg, state_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic [LIMIT_W-1:0] iter_reg, iter_next;
    logic [LIMIT_W:0]   iter_inc;

    assign iter_inc = {1'b0, iter_reg} + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            iter_reg  <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            iter_reg  <= iter_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        iter_next  = iter_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    iter_next  = '0;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                // Multiply one coordinate while the previous one is clamped.
                cmd.scale_mul  = (cnt_reg != SCALE_LAST);
                cmd.scale_sel  = axis_t'(cnt_reg);
                cmd.scale_wr   = (cnt_reg != '0);
                cmd.scale_wsel = axis_t'(cnt_reg - 2'd1);
                cnt_next       = cnt_reg + 2'd1;
                if (cnt_reg == SCALE_LAST) begin
                    cnt_next   = '0;
                    state_next = (iteration_limit == '0) ? ST_EMIT : ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                cmd.mul_issue = 1'b1;
                unique case (cnt_reg)
                    2'd0:    cmd.mul_op = MOP_XX;
                    2'd1:    cmd.mul_op = MOP_YY;
                    default: cmd.mul_op = MOP_ZZ;
                endcase
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == SQUARE_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_SQ_WAIT;
                end
            end
            ST_SQ_WAIT: begin
                if (status.pipe_empty) begin
                    state_next = ST_ADDS;
                end
            end
            ST_ADDS: begin
                cmd.adds   = 1'b1;
                state_next = ST_MUL_NY;
            end
            ST_MUL_NY: begin
                cmd.mul_issue = 1'b1;
                cmd.mul_op    = MOP_NY;
                cmd.upd_x     = 1'b1;
                state_next    = ST_MUL_NZ;
            end
            ST_MUL_NZ: begin
                cmd.mul_issue = 1'b1;
                cmd.mul_op    = MOP_NZ;
                state_next    = ST_MUL_XX;
            end
            ST_MUL_XX: begin
                cmd.mul_issue = 1'b1;
                cmd.mul_op    = MOP_XX;
                state_next    = ST_WAIT_XYZ;
            end
            ST_WAIT_XYZ: begin
                if (status.pipe_empty) begin
                    state_next = ST_UPD_YZ;
                end
            end
            ST_UPD_YZ: begin
                cmd.upd_yz = 1'b1;
                state_next = ST_MUL_YY;
            end
            ST_MUL_YY: begin
                cmd.mul_issue = 1'b1;
                cmd.mul_op    = MOP_YY;
                state_next    = ST_MUL_ZZ;
            end
            ST_MUL_ZZ: begin
                cmd.mul_issue = 1'b1;
                cmd.mul_op    = MOP_ZZ;
                state_next    = ST_WAIT_SQ;
            end
            ST_WAIT_SQ: begin
                if (status.pipe_empty) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                iter_next = iter_inc[LIMIT_W-1:0];
                if (status.escape) begin
                    state_next = ST_IDLE;
                end else if (iter_inc == {1'b0, iteration_limit}) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_ADDS;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
